// ===== rtl/bire_pkg.sv =====
// bire_pkg: shared types and constants of the bilinear image resampler.
// Used by the controller, datapath, register file, top level and checker.
// No dependencies.
`default_nettype none

package bire_pkg;

  // Fixed field widths
  localparam int FRAC_BITS   = 16;
  localparam int SAMPLE_BITS = 16;
  localparam int IDX_W       = 12;   // row / col on the input channel
  localparam int OUT_DIM     = 4096;
  localparam int CMP_W       = 13;   // holds any size or index up to 4096
  localparam int POS_W       = 30;   // 17-bit offset + 12x17 product
  localparam int WGT_W       = FRAC_BITS + 1;
  localparam int MUL_A_W     = SAMPLE_BITS + FRAC_BITS;
  localparam int ACC_W       = SAMPLE_BITS + 2 * FRAC_BITS;

  // Configuration register widths and reset values
  localparam int SIZE_W = 9;
  localparam int Q_W    = 17;
  localparam logic [SIZE_W-1:0] SRC_WIDTH_RST  = 9'd256;
  localparam logic [SIZE_W-1:0] SRC_HEIGHT_RST = 9'd256;
  localparam logic [Q_W-1:0]    STEP_RST       = 17'd65536;
  localparam logic [Q_W-1:0]    X_OFFSET_RST   = 17'd0;
  localparam logic [Q_W-1:0]    Y_OFFSET_RST   = 17'd0;

  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;

  // Input command codes
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef enum logic [2:0] {
    REG_SRC_WIDTH  = 3'd0,
    REG_SRC_HEIGHT = 3'd1,
    REG_STEP       = 3'd2,
    REG_X_OFFSET   = 3'd3,
    REG_Y_OFFSET   = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [SIZE_W-1:0] src_width;
    logic [SIZE_W-1:0] src_height;
    logic [Q_W-1:0]    step_q16;
    logic [Q_W-1:0]    x_offset_q16;
    logic [Q_W-1:0]    y_offset_q16;
  } cfg_regs_t;

  // Which neighbor the memory read fetches
  typedef enum logic [1:0] {
    RD_TL = 2'd0,
    RD_TR = 2'd1,
    RD_BL = 2'd2,
    RD_BR = 2'd3
  } rd_sel_t;

  // Shared multiply-accumulate operations
  typedef enum logic [2:0] {
    MAC_HOLD  = 3'd0,
    MAC_LEFT  = 3'd1,  // acc  = sample * (1 - fx)
    MAC_RIGHT = 3'd2,  // acc += sample * fx
    MAC_BOT   = 3'd3,  // acc  = bottom * fy + half
    MAC_TOP   = 3'd4   // acc += top * (1 - fy)
  } mac_op_t;

  typedef struct packed {
    logic    wr_en;
    logic    cap_en;
    logic    pos_en;
    logic    split_en;
    logic    rd_en;
    rd_sel_t rd_sel;
    mac_op_t mac_op;
    logic    save_top;
  } dp_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/bire_cfg.sv =====
// bire_cfg: APB-style configuration register file.
// Depends on bire_pkg.
`default_nettype none

module bire_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [bire_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [bire_pkg::PDATA_W-1:0]  pwdata,
  output logic      [bire_pkg::PDATA_W-1:0]  prdata,
  output logic                               pready,
  output bire_pkg::cfg_regs_t                cfg
);

  bire_pkg::cfg_regs_t cfg_r;
  bire_pkg::reg_idx_t  idx;
  logic                wr_txn;

  assign idx    = bire_pkg::reg_idx_t'(paddr[4:2]);
  assign wr_txn = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.src_width    <= bire_pkg::SRC_WIDTH_RST;
      cfg_r.src_height   <= bire_pkg::SRC_HEIGHT_RST;
      cfg_r.step_q16     <= bire_pkg::STEP_RST;
      cfg_r.x_offset_q16 <= bire_pkg::X_OFFSET_RST;
      cfg_r.y_offset_q16 <= bire_pkg::Y_OFFSET_RST;
    end else if (wr_txn) begin
      unique case (idx)
        bire_pkg::REG_SRC_WIDTH:  cfg_r.src_width    <= pwdata[bire_pkg::SIZE_W-1:0];
        bire_pkg::REG_SRC_HEIGHT: cfg_r.src_height   <= pwdata[bire_pkg::SIZE_W-1:0];
        bire_pkg::REG_STEP:       cfg_r.step_q16     <= pwdata[bire_pkg::Q_W-1:0];
        bire_pkg::REG_X_OFFSET:   cfg_r.x_offset_q16 <= pwdata[bire_pkg::Q_W-1:0];
        bire_pkg::REG_Y_OFFSET:   cfg_r.y_offset_q16 <= pwdata[bire_pkg::Q_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      bire_pkg::REG_SRC_WIDTH:  prdata = bire_pkg::PDATA_W'(cfg_r.src_width);
      bire_pkg::REG_SRC_HEIGHT: prdata = bire_pkg::PDATA_W'(cfg_r.src_height);
      bire_pkg::REG_STEP:       prdata = bire_pkg::PDATA_W'(cfg_r.step_q16);
      bire_pkg::REG_X_OFFSET:   prdata = bire_pkg::PDATA_W'(cfg_r.x_offset_q16);
      bire_pkg::REG_Y_OFFSET:   prdata = bire_pkg::PDATA_W'(cfg_r.y_offset_q16);
      default:                  prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/bire_ctrl.sv =====
// bire_ctrl: sequencer for the resampler; accepts transactions and steps the
// datapath through position, split, four neighbor reads and the blend.
// Depends on bire_pkg.
`default_nettype none

module bire_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic          in_cmd,
  output logic               busy,
  output logic               out_valid,
  output bire_pkg::dp_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_POS,
    S_SPLIT,
    S_RD_TL,
    S_RD_TR,
    S_RD_BL,
    S_RD_BR,
    S_HB,
    S_VB0,
    S_VB1
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r, busy_nxt;
  logic   strobe_r, strobe_nxt;
  logic   accept;

  assign accept    = start && !busy_r;
  assign busy      = busy_r;
  assign out_valid = strobe_r;

  always_comb begin
    state_nxt  = state_r;
    busy_nxt   = busy_r;
    strobe_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept && in_cmd == bire_pkg::CMD_QUERY) begin
          state_nxt = S_POS;
          busy_nxt  = 1'b1;
        end
      end
      S_POS:   state_nxt = S_SPLIT;
      S_SPLIT: state_nxt = S_RD_TL;
      S_RD_TL: state_nxt = S_RD_TR;
      S_RD_TR: state_nxt = S_RD_BL;
      S_RD_BL: state_nxt = S_RD_BR;
      S_RD_BR: state_nxt = S_HB;
      S_HB:    state_nxt = S_VB0;
      S_VB0:   state_nxt = S_VB1;
      S_VB1: begin
        state_nxt  = S_IDLE;
        busy_nxt   = 1'b0;
        strobe_nxt = 1'b1;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      busy_r   <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      busy_r   <= busy_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  // Datapath commands decoded from state; read data is registered and used in the state after its address
  always_comb begin
    cmd          = '0;
    cmd.rd_sel   = bire_pkg::RD_TL;
    cmd.mac_op   = bire_pkg::MAC_HOLD;
    unique case (state_r)
      S_IDLE: begin
        cmd.wr_en  = accept && in_cmd == bire_pkg::CMD_WRITE;
        cmd.cap_en = accept && in_cmd == bire_pkg::CMD_QUERY;
      end
      S_POS:   cmd.pos_en   = 1'b1;
      S_SPLIT: cmd.split_en = 1'b1;
      S_RD_TL: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = bire_pkg::RD_TL;
      end
      S_RD_TR: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = bire_pkg::RD_TR;
        cmd.mac_op = bire_pkg::MAC_LEFT;
      end
      S_RD_BL: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = bire_pkg::RD_BL;
        cmd.mac_op = bire_pkg::MAC_RIGHT;
      end
      S_RD_BR: begin
        cmd.rd_en    = 1'b1;
        cmd.rd_sel   = bire_pkg::RD_BR;
        cmd.mac_op   = bire_pkg::MAC_LEFT;
        cmd.save_top = 1'b1;
      end
      S_HB:    cmd.mac_op = bire_pkg::MAC_RIGHT;
      S_VB0:   cmd.mac_op = bire_pkg::MAC_BOT;
      S_VB1:   cmd.mac_op = bire_pkg::MAC_TOP;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/bire_dp.sv =====
// bire_dp: resampler datapath: source image memory, position multipliers,
// index split and clamp, and the shared multiply-accumulate for the blend.
// Depends on bire_pkg.
`default_nettype none

module bire_dp #(
  parameter int SRC_DIM = 256
) (
  input  wire logic                                clk,
  input  wire bire_pkg::dp_cmd_t                   cmd,
  input  wire bire_pkg::cfg_regs_t                 cfg,
  input  wire logic [bire_pkg::IDX_W-1:0]          in_row,
  input  wire logic [bire_pkg::IDX_W-1:0]          in_col,
  input  wire logic [bire_pkg::SAMPLE_BITS-1:0]    in_sample,
  output logic      [bire_pkg::SAMPLE_BITS-1:0]    pixel_value,
  output logic                                     out_of_range
);

  localparam int F     = bire_pkg::FRAC_BITS;
  localparam int SB    = bire_pkg::SAMPLE_BITS;
  localparam int CW    = bire_pkg::CMP_W;
  localparam int PW    = bire_pkg::POS_W;
  localparam int IPW   = PW - F;
  localparam int XW    = bire_pkg::IDX_W;
  localparam int QW    = bire_pkg::Q_W;
  localparam int WW    = bire_pkg::WGT_W;
  localparam int AW_M  = bire_pkg::MUL_A_W;
  localparam int ACW   = bire_pkg::ACC_W;
  localparam int PRW   = AW_M + WW;
  localparam int IW    = $clog2(SRC_DIM);
  localparam int DEPTH = SRC_DIM * SRC_DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int MW    = XW + QW;

  localparam logic [WW-1:0]  ONE_Q = WW'(1) << F;
  localparam logic [ACW-1:0] HALF  = ACW'(1) << (2 * F - 1);

  logic [SB-1:0] mem [DEPTH];

  logic [XW-1:0]  row_r, col_r;
  logic [PW-1:0]  px_r, py_r;
  logic [IW-1:0]  c0_r, c1_r, r0_r, r1_r;
  logic [F-1:0]   fx_r, fy_r;
  logic           oor_r;
  logic [SB-1:0]  rd_data_r;
  logic [AW_M-1:0] top_r;
  logic [ACW-1:0] acc_r;

  // Effective image size, saturated to 1..SRC_DIM
  logic [CW-1:0] w_eff, h_eff, last_x, last_y;

  always_comb begin
    if (cfg.src_width == '0)                           w_eff = CW'(1);
    else if (CW'(cfg.src_width) > CW'(SRC_DIM))        w_eff = CW'(SRC_DIM);
    else                                               w_eff = CW'(cfg.src_width);
    if (cfg.src_height == '0)                          h_eff = CW'(1);
    else if (CW'(cfg.src_height) > CW'(SRC_DIM))       h_eff = CW'(SRC_DIM);
    else                                               h_eff = CW'(cfg.src_height);
  end

  assign last_x = w_eff - CW'(1);
  assign last_y = h_eff - CW'(1);

  // Sample write
  logic          wr_ok;
  logic [AW-1:0] wr_addr;

  assign wr_ok   = cmd.wr_en && (CW'(in_row) < h_eff) && (CW'(in_col) < w_eff);
  assign wr_addr = AW'(in_row[IW-1:0]) * AW'(SRC_DIM) + AW'(in_col[IW-1:0]);

  // Neighbor read
  logic [IW-1:0] rd_r_idx, rd_c_idx;
  logic [AW-1:0] rd_addr;

  always_comb begin
    case (cmd.rd_sel)
      bire_pkg::RD_TL: begin rd_r_idx = r0_r; rd_c_idx = c0_r; end
      bire_pkg::RD_TR: begin rd_r_idx = r0_r; rd_c_idx = c1_r; end
      bire_pkg::RD_BL: begin rd_r_idx = r1_r; rd_c_idx = c0_r; end
      bire_pkg::RD_BR: begin rd_r_idx = r1_r; rd_c_idx = c1_r; end
      default:         begin rd_r_idx = r0_r; rd_c_idx = c0_r; end
    endcase
  end

  assign rd_addr = AW'(rd_r_idx) * AW'(SRC_DIM) + AW'(rd_c_idx);

  always_ff @(posedge clk) begin
    if (wr_ok) mem[wr_addr] <= in_sample;
    if (cmd.rd_en) rd_data_r <= mem[rd_addr];
  end

  // Source position: offset + index * step
  logic [MW-1:0] prod_x, prod_y;

  assign prod_x = MW'(col_r) * MW'(cfg.step_q16);
  assign prod_y = MW'(row_r) * MW'(cfg.step_q16);

  // Split into clamped indices, fraction and range flag
  logic [IPW-1:0] ipx, ipy, lx, ly;
  logic [IPW:0]   ipx_p1, ipy_p1;
  logic [IW-1:0]  c0_nxt, c1_nxt, r0_nxt, r1_nxt;
  logic           oorx, oory, oor_idx;

  assign ipx    = px_r[PW-1:F];
  assign ipy    = py_r[PW-1:F];
  assign lx     = IPW'(last_x);
  assign ly     = IPW'(last_y);
  assign ipx_p1 = (IPW+1)'(ipx) + (IPW+1)'(1);
  assign ipy_p1 = (IPW+1)'(ipy) + (IPW+1)'(1);

  assign c0_nxt = (ipx < lx) ? ipx[IW-1:0] : last_x[IW-1:0];
  assign r0_nxt = (ipy < ly) ? ipy[IW-1:0] : last_y[IW-1:0];
  assign c1_nxt = (ipx_p1 < (IPW+1)'(last_x)) ? ipx_p1[IW-1:0] : last_x[IW-1:0];
  assign r1_nxt = (ipy_p1 < (IPW+1)'(last_y)) ? ipy_p1[IW-1:0] : last_y[IW-1:0];

  // Past the last sample once the integer part exceeds it, or equals it with a fraction
  assign oorx    = (ipx > lx) || (ipx == lx && px_r[F-1:0] != '0);
  assign oory    = (ipy > ly) || (ipy == ly && py_r[F-1:0] != '0);
  assign oor_idx = (CW'(row_r) >= CW'(bire_pkg::OUT_DIM)) ||
                   (CW'(col_r) >= CW'(bire_pkg::OUT_DIM));

  always_ff @(posedge clk) begin
    if (cmd.cap_en) begin
      row_r <= in_row;
      col_r <= in_col;
    end
    if (cmd.pos_en) begin
      px_r <= PW'(prod_x) + PW'(cfg.x_offset_q16);
      py_r <= PW'(prod_y) + PW'(cfg.y_offset_q16);
    end
    if (cmd.split_en) begin
      c0_r  <= c0_nxt;
      c1_r  <= c1_nxt;
      r0_r  <= r0_nxt;
      r1_r  <= r1_nxt;
      fx_r  <= px_r[F-1:0];
      fy_r  <= py_r[F-1:0];
      oor_r <= oorx || oory || oor_idx;
    end
  end

  // Shared multiply-accumulate: one product per cycle; acc_r holds on MAC_HOLD
  logic [WW-1:0]   nfx, nfy;
  logic [AW_M-1:0] mac_a;
  logic [WW-1:0]   mac_b;
  logic [ACW-1:0]  mac_add;
  logic [PRW-1:0]  mac_prod;
  logic [ACW-1:0]  acc_nxt;

  assign nfx = ONE_Q - WW'(fx_r);
  assign nfy = ONE_Q - WW'(fy_r);

  always_comb begin
    case (cmd.mac_op)
      bire_pkg::MAC_LEFT: begin
        mac_a = AW_M'(rd_data_r); mac_b = nfx;         mac_add = '0;
      end
      bire_pkg::MAC_RIGHT: begin
        mac_a = AW_M'(rd_data_r); mac_b = WW'(fx_r);   mac_add = acc_r;
      end
      bire_pkg::MAC_BOT: begin
        mac_a = acc_r[AW_M-1:0];  mac_b = WW'(fy_r);   mac_add = HALF;
      end
      bire_pkg::MAC_TOP: begin
        mac_a = top_r;            mac_b = nfy;         mac_add = acc_r;
      end
      default: begin
        mac_a = '0;               mac_b = '0;          mac_add = acc_r;
      end
    endcase
  end

  assign mac_prod = PRW'(mac_a) * PRW'(mac_b);
  assign acc_nxt  = ACW'(mac_prod) + mac_add;

  always_ff @(posedge clk) begin
    if (cmd.mac_op != bire_pkg::MAC_HOLD) acc_r <= acc_nxt;
    if (cmd.save_top) top_r <= acc_r[AW_M-1:0];
  end

  assign pixel_value  = acc_r[ACW-1:2*F];
  assign out_of_range = oor_r;

endmodule

`default_nettype wire

// ===== rtl/bilinear_image_resampler_unit.sv =====
// bilinear_image_resampler_unit: top level of the bilinear image resampler.
// Depends on bire_pkg, bire_cfg, bire_ctrl and bire_dp.
//
// Usage:
//   Input channel: a transaction is taken at a rising edge with start high and
//   busy low. in_cmd = write stores in_sample at (in_row, in_col) of the source
//   image; a write outside the configured size is dropped. in_cmd = query asks
//   for output pixel (in_row, in_col).
//   Writes take effect at the accept edge and leave busy low, so one write per
//   cycle is sustained while no query holds busy. A query raises busy while
//   the sequencer runs; its result shows on out_pixel_value / out_out_of_range
//   with out_valid high for one cycle, and busy is low in that cycle. A query
//   is taken only once the previous one is done, as set by the single read port
//   of the image memory (four neighbor reads) and the shared MAC (six products).
//   The receiver cannot stall: out_valid is a one-cycle strobe.
//   Configuration is through the APB-style port (regs at byte offsets 0..16:
//   width, height, step, x offset, y offset); write it only while idle.
//   Reset (rst_n low, synchronous) returns the registers to their defaults and
//   the sequencer to idle. The image memory is not cleared; unwritten samples
//   read as unknown values.
`default_nettype none

module bilinear_image_resampler_unit #(
  parameter int SRC_DIM = 256
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic                                in_cmd,
  input  wire logic [bire_pkg::IDX_W-1:0]          in_row,
  input  wire logic [bire_pkg::IDX_W-1:0]          in_col,
  input  wire logic [bire_pkg::SAMPLE_BITS-1:0]    in_sample,
  output logic                                     out_valid,
  output logic      [bire_pkg::SAMPLE_BITS-1:0]    out_pixel_value,
  output logic                                     out_out_of_range,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [bire_pkg::PADDR_W-1:0]        paddr,
  input  wire logic [bire_pkg::PDATA_W-1:0]        pwdata,
  output logic      [bire_pkg::PDATA_W-1:0]        prdata,
  output logic                                     pready
);

  bire_pkg::cfg_regs_t cfg;
  bire_pkg::dp_cmd_t   dp_cmd;

  bire_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bire_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_cmd    (in_cmd),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (dp_cmd)
  );

  bire_dp #(
    .SRC_DIM (SRC_DIM)
  ) u_dp (
    .clk          (clk),
    .cmd          (dp_cmd),
    .cfg          (cfg),
    .in_row       (in_row),
    .in_col       (in_col),
    .in_sample    (in_sample),
    .pixel_value  (out_pixel_value),
    .out_of_range (out_out_of_range)
  );

endmodule

`default_nettype wire

// ===== rtl/bire_checker.sv =====
// bire_checker: port-level assertions for the resampler, bound to the top level.
// Depends on bire_pkg and bilinear_image_resampler_unit.
`default_nettype none

module bire_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  input wire logic busy,
  input wire logic in_cmd,
  input wire logic out_valid
);

  // A write transaction never blocks the next one
  a_write_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_cmd == bire_pkg::CMD_WRITE |=> !busy)
    else $error("busy raised by a write transaction");

  // A query transaction holds off further input
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_cmd == bire_pkg::CMD_QUERY |=> busy)
    else $error("query accepted without raising busy");

  // Query result comes back at a fixed latency
  a_query_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_cmd == bire_pkg::CMD_QUERY |-> ##10 out_valid)
    else $error("query result missing at expected latency");

  // A result only ends a busy period
  a_result_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy && $past(busy))
    else $error("result strobe without a finished query");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

endmodule

bind bilinear_image_resampler_unit bire_checker u_bire_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_cmd    (in_cmd),
  .out_valid (out_valid)
);

`default_nettype wire

// ===== sim/testbench.sv =====
// testbench: self-checking bench for bilinear_image_resampler_unit; drives write and
// query traffic across register settings and checks each pixel against a predictor.
// Depends on bire_pkg and the resampler RTL.

module testbench;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 12;
  localparam int PHASE_ITEMS    = 125;
  localparam int NUM_PHASES     = 10;

  class pixel_scoreboard;
    typedef struct packed {
      bit [bire_pkg::SAMPLE_BITS-1:0] pix;
      bit                             oor;
    } pixel_result_t;

    bit [bire_pkg::SAMPLE_BITS-1:0] image [65536];
    bit                             written [65536];
    bit [bire_pkg::SIZE_W-1:0]      width_r;
    bit [bire_pkg::SIZE_W-1:0]      height_r;
    bit [bire_pkg::Q_W-1:0]         step_r;
    bit [bire_pkg::Q_W-1:0]         x_off_r;
    bit [bire_pkg::Q_W-1:0]         y_off_r;
    pixel_result_t                  expected_pixels[$];
    int                             err_cnt;

    function new();
      width_r  = bire_pkg::SRC_WIDTH_RST;
      height_r = bire_pkg::SRC_HEIGHT_RST;
      step_r   = bire_pkg::STEP_RST;
      x_off_r  = bire_pkg::X_OFFSET_RST;
      y_off_r  = bire_pkg::Y_OFFSET_RST;
      err_cnt  = 0;
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      err_cnt++;
    endtask

    function bit [63:0] clamp_dim(bit [bire_pkg::SIZE_W-1:0] v);
      if (v == 0) return 1;
      if (v > 256) return 256;
      return v;
    endfunction

    function void write_reg(bire_pkg::reg_idx_t idx, bit [bire_pkg::PDATA_W-1:0] v);
      case (idx)
        bire_pkg::REG_SRC_WIDTH:  width_r  = v[bire_pkg::SIZE_W-1:0];
        bire_pkg::REG_SRC_HEIGHT: height_r = v[bire_pkg::SIZE_W-1:0];
        bire_pkg::REG_STEP:       step_r   = v[bire_pkg::Q_W-1:0];
        bire_pkg::REG_X_OFFSET:   x_off_r  = v[bire_pkg::Q_W-1:0];
        bire_pkg::REG_Y_OFFSET:   y_off_r  = v[bire_pkg::Q_W-1:0];
        default: ;
      endcase
    endfunction

    // Lower/upper neighbor index clamped to the edge, fraction, beyond-edge flag
    function void split_axis(input bit [63:0] pos, input bit [63:0] size,
                             output bit [63:0] lo, output bit [63:0] hi,
                             output bit [63:0] frac, output bit beyond);
      bit [63:0] last;
      bit [63:0] ip;
      last   = size - 1;
      ip     = pos >> bire_pkg::FRAC_BITS;
      frac   = pos & 64'hFFFF;
      lo     = (ip < last) ? ip : last;
      hi     = (ip + 1 < last) ? ip + 1 : last;
      beyond = pos > (last << bire_pkg::FRAC_BITS);
    endfunction

    function bit [63:0] pel(bit [63:0] r, bit [63:0] c);
      return image[(r * 256 + c) % 65536];
    endfunction

    function bit is_written(bit [63:0] r, bit [63:0] c);
      return written[(r * 256 + c) % 65536];
    endfunction

    // First neighbor of a query that was never written, if any
    function bit find_hole(input bit [bire_pkg::IDX_W-1:0] row,
                           input bit [bire_pkg::IDX_W-1:0] col,
                           output bit [bire_pkg::IDX_W-1:0] hr,
                           output bit [bire_pkg::IDX_W-1:0] hc);
      bit [63:0] px, py, c0, c1, fx, r0, r1, fy;
      bit        ox, oy;
      px = x_off_r + col * step_r;
      py = y_off_r + row * step_r;
      split_axis(px, clamp_dim(width_r), c0, c1, fx, ox);
      split_axis(py, clamp_dim(height_r), r0, r1, fy, oy);
      hr = bire_pkg::IDX_W'(r0);
      hc = bire_pkg::IDX_W'(c0);
      if (!is_written(r0, c0)) return 1;
      hc = bire_pkg::IDX_W'(c1);
      if (!is_written(r0, c1)) return 1;
      hr = bire_pkg::IDX_W'(r1);
      hc = bire_pkg::IDX_W'(c0);
      if (!is_written(r1, c0)) return 1;
      hc = bire_pkg::IDX_W'(c1);
      if (!is_written(r1, c1)) return 1;
      return 0;
    endfunction

    function pixel_result_t bilinear_blend(bit [bire_pkg::IDX_W-1:0] row,
                                           bit [bire_pkg::IDX_W-1:0] col);
      pixel_result_t res;
      bit [63:0] px, py, c0, c1, fx, r0, r1, fy, one;
      bit [63:0] top, bot, a, b, val;
      bit        ox, oy;
      one = 64'd1 << bire_pkg::FRAC_BITS;
      px  = x_off_r + col * step_r;
      py  = y_off_r + row * step_r;
      split_axis(px, clamp_dim(width_r), c0, c1, fx, ox);
      split_axis(py, clamp_dim(height_r), r0, r1, fy, oy);
      top = pel(r0, c0) * (one - fx) + pel(r0, c1) * fx;
      bot = pel(r1, c0) * (one - fx) + pel(r1, c1) * fx;
      // single rounding of the exact product, halves up
      a   = (top >> bire_pkg::FRAC_BITS) * (one - fy) + (bot >> bire_pkg::FRAC_BITS) * fy;
      b   = (top & 64'hFFFF) * (one - fy) + (bot & 64'hFFFF) * fy + ((one * one) >> 1);
      val = (a + (b >> bire_pkg::FRAC_BITS)) >> bire_pkg::FRAC_BITS;
      res.pix = val[bire_pkg::SAMPLE_BITS-1:0];
      res.oor = ox || oy || (row >= bire_pkg::OUT_DIM) || (col >= bire_pkg::OUT_DIM);
      return res;
    endfunction

    function void note_input(bit cmd, bit [bire_pkg::IDX_W-1:0] row,
                             bit [bire_pkg::IDX_W-1:0] col,
                             bit [bire_pkg::SAMPLE_BITS-1:0] smp);
      if (cmd == bire_pkg::CMD_WRITE) begin
        if (row < clamp_dim(height_r) && col < clamp_dim(width_r)) begin
          image[{row[7:0], col[7:0]}]   = smp;
          written[{row[7:0], col[7:0]}] = 1'b1;
        end
      end else begin
        expected_pixels.push_back(bilinear_blend(row, col));
      end
    endfunction

    task check_result(logic [bire_pkg::SAMPLE_BITS-1:0] pix, logic oor);
      pixel_result_t exp_px;
      if (expected_pixels.size() == 0) begin
        report("result strobe with no query outstanding");
      end else begin
        exp_px = expected_pixels.pop_front();
        if (pix !== exp_px.pix)
          report($sformatf("pixel_value got %h want %h", pix, exp_px.pix));
        if (oor !== exp_px.oor)
          report($sformatf("out_of_range got %b want %b", oor, exp_px.oor));
      end
    endtask
  endclass

  logic                             clk;
  logic                             rst_n;
  logic                             start;
  logic                             in_cmd;
  logic [bire_pkg::IDX_W-1:0]       in_row;
  logic [bire_pkg::IDX_W-1:0]       in_col;
  logic [bire_pkg::SAMPLE_BITS-1:0] in_sample;
  logic                             psel;
  logic                             penable;
  logic                             pwrite;
  logic [bire_pkg::PADDR_W-1:0]     paddr;
  logic [bire_pkg::PDATA_W-1:0]     pwdata;
  wire                              busy;
  wire                              out_valid;
  wire [bire_pkg::SAMPLE_BITS-1:0]  out_pixel_value;
  wire                              out_out_of_range;
  wire [bire_pkg::PDATA_W-1:0]      prdata;
  wire                              pready;

  pixel_scoreboard sb;
  int              idle_cycles;

  bilinear_image_resampler_unit u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_cmd           (in_cmd),
    .in_row           (in_row),
    .in_col           (in_col),
    .in_sample        (in_sample),
    .out_valid        (out_valid),
    .out_pixel_value  (out_pixel_value),
    .out_out_of_range (out_out_of_range),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1)
      sb.check_result(out_pixel_value, out_out_of_range);
  end

  // any accepted transaction resets the stall counter
  always @(posedge clk) begin
    if ((start === 1'b1 && busy === 1'b0) || out_valid === 1'b1 ||
        (psel === 1'b1 && penable === 1'b1 && pwrite === 1'b1 && pready === 1'b1))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic send(bit cmd, bit [bire_pkg::IDX_W-1:0] r, bit [bire_pkg::IDX_W-1:0] c,
                      bit [bire_pkg::SAMPLE_BITS-1:0] s);
    @(negedge clk);
    start     <= 1'b1;
    in_cmd    <= cmd;
    in_row    <= r;
    in_col    <= c;
    in_sample <= s;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_input(cmd, r, c, s);
  endtask

  // Write any unwritten neighbor of the position first, then send the query
  task automatic query(bit [bire_pkg::IDX_W-1:0] r, bit [bire_pkg::IDX_W-1:0] c);
    bit [bire_pkg::IDX_W-1:0] hr;
    bit [bire_pkg::IDX_W-1:0] hc;
    while (sb.find_hole(r, c, hr, hc))
      send(bire_pkg::CMD_WRITE, hr, hc, bire_pkg::SAMPLE_BITS'($urandom));
    send(bire_pkg::CMD_QUERY, r, c, '0);
  endtask

  task automatic pause_input(int n);
    repeat (n) begin
      @(negedge clk);
      start     <= 1'b0;
      in_cmd    <= 1'($urandom);
      in_row    <= bire_pkg::IDX_W'($urandom);
      in_col    <= bire_pkg::IDX_W'($urandom);
      in_sample <= bire_pkg::SAMPLE_BITS'($urandom);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    start <= 1'b0;
    while (sb.expected_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(bire_pkg::reg_idx_t idx, bit [bire_pkg::PDATA_W-1:0] v);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= v;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    sb.write_reg(idx, v);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic cfg_all(int w, int h, int st, int xo, int yo);
    cfg_write(bire_pkg::REG_SRC_WIDTH, w);
    cfg_write(bire_pkg::REG_SRC_HEIGHT, h);
    cfg_write(bire_pkg::REG_STEP, st);
    cfg_write(bire_pkg::REG_X_OFFSET, xo);
    cfg_write(bire_pkg::REG_Y_OFFSET, yo);
  endtask

  function automatic int pick_dim();
    case ($urandom_range(0, 5))
      0: return 256;
      1: return 1;
      2: return $urandom_range(0, 511);
      default: return $urandom_range(1, 256);
    endcase
  endfunction

  function automatic int pick_step();
    case ($urandom_range(0, 5))
      0: return 65536;
      1: return 1;
      2: return $urandom_range(0, 131071);
      3: return $urandom_range(1, 65536);
      default: return $urandom_range(4096, 65536);
    endcase
  endfunction

  function automatic int pick_offset();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 131071;
      default: return $urandom_range(0, 131071);
    endcase
  endfunction

  // highest output index whose position still lands inside the image, plus one
  function automatic int reach(bit [bire_pkg::SIZE_W-1:0] dim, bit [bire_pkg::Q_W-1:0] off);
    longint span;
    if (sb.step_r == 0) return 4095;
    span = (longint'(sb.clamp_dim(dim) - 1) << bire_pkg::FRAC_BITS) - longint'(off);
    if (span < 0) return 1;
    span = span / sb.step_r + 1;
    return (span > 4095) ? 4095 : int'(span);
  endfunction

  initial begin
    int                             p;
    int                             i;
    bit                             calm;
    bit                             cmd;
    bit [bire_pkg::IDX_W-1:0]       r;
    bit [bire_pkg::IDX_W-1:0]       c;
    bit [bire_pkg::IDX_W-1:0]       hr;
    bit [bire_pkg::IDX_W-1:0]       hc;
    bit [bire_pkg::SAMPLE_BITS-1:0] s;
    int                             lim_r;
    int                             lim_c;

    sb          = new();
    idle_cycles = 0;
    rst_n       = 1'b0;
    start       = 1'b0;
    in_cmd      = bire_pkg::CMD_WRITE;
    in_row      = '0;
    in_col      = '0;
    in_sample   = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Corner patterns for the rounding cases; other samples are written on demand
    cfg_all(256, 256, 65536, 0, 0);
    send(bire_pkg::CMD_WRITE, 0, 0, 16'hFFFF);
    send(bire_pkg::CMD_WRITE, 0, 1, 16'h0000);
    send(bire_pkg::CMD_WRITE, 1, 0, 16'h0000);
    send(bire_pkg::CMD_WRITE, 1, 1, 16'hFFFF);
    send(bire_pkg::CMD_WRITE, 255, 254, 16'h0000);
    send(bire_pkg::CMD_WRITE, 255, 255, 16'hFFFF);

    // Directed: half-pixel step, rounding on extreme corners, edges
    wait_drained();
    cfg_write(bire_pkg::REG_STEP, 32768);
    query(0, 0);
    query(0, 1);
    query(1, 1);
    query(1, 0);
    query(510, 510);
    query(511, 509);
    query(4095, 4095);
    send(bire_pkg::CMD_WRITE, 0, 0, 16'h1234);
    send(bire_pkg::CMD_WRITE, 4095, 4095, 16'hFFFF);
    send(bire_pkg::CMD_WRITE, 256, 0, 16'hFFFF);
    send(bire_pkg::CMD_WRITE, 255, 255, 16'h0000);
    query(0, 0);
    query(510, 510);

    // Zero width acts as one, oversize height acts as full, zero step
    wait_drained();
    cfg_all(0, 511, 0, 131071, 131071);
    query(0, 0);
    query(4095, 4095);
    send(bire_pkg::CMD_WRITE, 0, 1, 16'hAAAA);

    // Tiny image, smallest step
    wait_drained();
    cfg_all(2, 2, 1, 32768, 0);
    query(0, 0);
    query(0, 4095);
    query(4095, 0);

    // Step near two source pixels
    wait_drained();
    cfg_all(256, 256, 131071, 0, 0);
    query(0, 255);
    query(0, 127);
    query(127, 1);

    for (p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      if (p == 0)
        cfg_all(256, 256, 65536, 131071, 131071);
      else if (p == 1)
        cfg_all(1, 1, 1, 0, 0);
      else
        cfg_all(pick_dim(), pick_dim(), pick_step(), pick_offset(), pick_offset());
      calm  = (p == NUM_PHASES - 1) || ($urandom_range(0, 2) == 0);
      lim_c = reach(sb.width_r, sb.x_off_r);
      lim_r = reach(sb.height_r, sb.y_off_r);
      i = 0;
      while (i < PHASE_ITEMS) begin
        if (!calm && $urandom_range(0, 5) == 0)
          pause_input($urandom_range(1, 19));
        cmd = ($urandom_range(0, 9) < 3) ? bire_pkg::CMD_WRITE : bire_pkg::CMD_QUERY;
        s   = bire_pkg::SAMPLE_BITS'($urandom);
        if ($urandom_range(0, 7) == 0)
          s = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        if ($urandom_range(0, 3) == 0) begin
          r = bire_pkg::IDX_W'($urandom);
          c = bire_pkg::IDX_W'($urandom);
        end else if (cmd == bire_pkg::CMD_WRITE) begin
          r = bire_pkg::IDX_W'($urandom_range(0, int'(sb.clamp_dim(sb.height_r)) - 1));
          c = bire_pkg::IDX_W'($urandom_range(0, int'(sb.clamp_dim(sb.width_r)) - 1));
        end else begin
          r = bire_pkg::IDX_W'($urandom_range(0, lim_r));
          c = bire_pkg::IDX_W'($urandom_range(0, lim_c));
        end
        // a query only reads samples that were written before it
        if (cmd == bire_pkg::CMD_QUERY) begin
          while (i < PHASE_ITEMS - 1 && sb.find_hole(r, c, hr, hc)) begin
            send(bire_pkg::CMD_WRITE, hr, hc, bire_pkg::SAMPLE_BITS'($urandom));
            i++;
          end
          if (sb.find_hole(r, c, hr, hc)) begin
            cmd = bire_pkg::CMD_WRITE;
            r   = hr;
            c   = hc;
          end
        end
        send(cmd, r, c, s);
        i++;
      end
    end

    wait_drained();
    if (sb.err_cnt == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
